// ----- design/bpc_pkg.sv -----
// Shared types and constants for the barometric pressure compensation pipeline.
package bpc_pkg;

  localparam int DivSteps  = 32;
  localparam int PreStages = 3;
  localparam int MidStages = 6;
  localparam int EndStages = 4;
  localparam int Stages    = PreStages + DivSteps + MidStages + DivSteps + EndStages;

  typedef enum logic [2:0] {
    RegAc1Ac2  = 3'd0,
    RegAc3Ac4  = 3'd1,
    RegAc5Ac6  = 3'd2,
    RegB1B2    = 3'd3,
    RegMcMd    = 3'd4,
    RegOversmp = 3'd5
  } cfg_reg_e;

  // One request as it travels the pipeline; each stage fills in its fields.
  typedef struct packed {
    logic [15:0] ut;
    logic [18:0] up;
    logic [31:0] x1;
    logic [31:0] a;     // dividend, becomes the quotient
    logic [31:0] d;     // divisor
    logic [31:0] r;     // partial remainder
    logic        neg;
    logic        dz;    // temperature divisor zero
    logic        bz;    // pressure divisor zero
    logic        dbl;
    logic [31:0] b5;
    logic [31:0] b6;
    logic [15:0] temp;
    logic [31:0] b6sq;
    logic [31:0] x2a;
    logic [31:0] x1c;
    logic [31:0] x1a;
    logic [31:0] x2c;
    logic [31:0] b3;
    logic [31:0] x3c;
    logic [31:0] b4;
    logic [31:0] p;
    logic [31:0] px1;
    logic [31:0] px2;
    logic [31:0] px1b;
    logic [17:0] pa;
  } item_t;

  // One restoring division step: one quotient bit.
  function automatic item_t div_step(item_t it);
    item_t       o;
    logic [32:0] t;
    logic [32:0] s;
    o = it;
    t = {it.r, it.a[31]};
    s = t - {1'b0, it.d};
    if (!s[32]) begin
      o.r = s[31:0];
      o.a = {it.a[30:0], 1'b1};
    end else begin
      o.r = t[31:0];
      o.a = {it.a[30:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// ----- design/barometric_pressure_compensation.sv -----
// Two 32-step restoring dividers (one quotient bit per stage) set the depth.
// Throughput: one request per cycle; a stall at the output freezes every stage.
// Reset: all stage valid bits clear, calibration registers clear to zero and
// oversampling resets to 3.
module barometric_pressure_compensation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] raw_temperature_i,
  input  logic [18:0] raw_pressure_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] temperature_tenths_o,
  output logic [17:0] pressure_pa_o,
  output logic        math_error_o
);

  logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;
  logic [1:0]  oss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac12_q <= '0;
      ac34_q <= '0;
      ac56_q <= '0;
      b12_q  <= '0;
      mcmd_q <= '0;
      oss_q  <= 2'd3;
    end else if (cfg_we_i) begin
      case (bpc_pkg::cfg_reg_e'(cfg_index_i))
        bpc_pkg::RegAc1Ac2:  ac12_q <= cfg_data_i;
        bpc_pkg::RegAc3Ac4:  ac34_q <= cfg_data_i;
        bpc_pkg::RegAc5Ac6:  ac56_q <= cfg_data_i;
        bpc_pkg::RegB1B2:    b12_q  <= cfg_data_i;
        bpc_pkg::RegMcMd:    mcmd_q <= cfg_data_i;
        bpc_pkg::RegOversmp: oss_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = {{16{ac12_q[31]}}, ac12_q[31:16]};
  assign ac2 = {{16{ac12_q[15]}}, ac12_q[15:0]};
  assign ac3 = {{16{ac34_q[31]}}, ac34_q[31:16]};
  assign ac4 = {16'd0, ac34_q[15:0]};
  assign ac5 = {16'd0, ac56_q[31:16]};
  assign ac6 = {16'd0, ac56_q[15:0]};
  assign b1  = {{16{b12_q[31]}}, b12_q[31:16]};
  assign b2  = {{16{b12_q[15]}}, b12_q[15:0]};
  assign mc  = {{16{mcmd_q[31]}}, mcmd_q[31:16]};
  assign md  = {{16{mcmd_q[15]}}, mcmd_q[15:0]};

  logic en;
  logic [bpc_pkg::Stages-1:0] vld_q;

  assign en          = !(vld_q[bpc_pkg::Stages-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[bpc_pkg::Stages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[bpc_pkg::Stages-2:0], in_valid_i};
    end
  end

  bpc_pkg::item_t s0_q, s1_q, s2_q, s3_q, s4_q, s5_q, s6_q, s7_q, s8_q;
  bpc_pkg::item_t s9_q, s10_q, s11_q, s12_q;
  bpc_pkg::item_t dv1_q [bpc_pkg::DivSteps];
  bpc_pkg::item_t dv2_q [bpc_pkg::DivSteps];
  bpc_pkg::item_t c0, c1, c2, c3, c4, c5, c6, c7, c8, c9, c10, c11, c12;

  logic [31:0] prod1, num1, den1, q1, x2t, b5t, tt, m1, m2, m3, m4, m5;
  logic [31:0] x3, v3, x3c, b4p, b7, pp, pf, pm1, pm2;

  always_comb begin
    c0    = '0;
    c0.ut = raw_temperature_i;
    c0.up = raw_pressure_i;

    // x1 = (ut - ac6) * ac5 >> 15
    c1    = s0_q;
    prod1 = ({16'd0, s0_q.ut} - ac6) * ac5;
    c1.x1 = 32'($signed(prod1) >>> 15);

    // prepare magnitude division mc<<11 / (x1 + md)
    c2     = s1_q;
    num1   = mc << 11;
    den1   = s1_q.x1 + md;
    c2.dz  = (den1 == 32'd0);
    c2.neg = num1[31] ^ den1[31];
    c2.a   = num1[31] ? -num1 : num1;
    c2.d   = den1[31] ? -den1 : den1;
    c2.r   = '0;

    // b5, temperature, b6
    c3    = dv1_q[bpc_pkg::DivSteps-1];
    q1    = c3.a;
    x2t   = c3.neg ? -q1 : q1;
    b5t   = c3.x1 + x2t;
    c3.b5 = b5t;
    c3.b6 = b5t - 32'd4000;
    tt    = 32'($signed(b5t + 32'd8) >>> 4);
    if (c3.dz) begin
      c3.temp = '0;
    end else if (!tt[31] && tt[30:15] != 16'd0) begin
      c3.temp = 16'h7fff;
    end else if (tt[31] && tt[30:15] != 16'hffff) begin
      c3.temp = 16'h8000;
    end else begin
      c3.temp = tt[15:0];
    end

    c4      = s3_q;
    m1      = s3_q.b6 * s3_q.b6;
    m2      = ac2 * s3_q.b6;
    m3      = ac3 * s3_q.b6;
    c4.b6sq = 32'($signed(m1) >>> 12);
    c4.x2a  = 32'($signed(m2) >>> 11);
    c4.x1c  = 32'($signed(m3) >>> 13);

    c5     = s4_q;
    m4     = b2 * s4_q.b6sq;
    m5     = b1 * s4_q.b6sq;
    c5.x1a = 32'($signed(m4) >>> 11);
    c5.x2c = 32'($signed(m5) >>> 16);

    // b3: signed divide by four truncating toward zero
    c6     = s5_q;
    x3     = s5_q.x1a + s5_q.x2a;
    v3     = (((ac1 << 2) + x3) << oss_q) + 32'd2;
    c6.b3  = v3[31] ? 32'($signed(v3 + 32'd3) >>> 2) : (v3 >> 2);
    x3c    = 32'($signed(s5_q.x1c + s5_q.x2c + 32'd2) >>> 2);
    c6.x3c = x3c;

    c7    = s6_q;
    b4p   = ac4 * (s6_q.x3c + 32'd32768);
    c7.b4 = b4p >> 15;
    c7.bz = (c7.b4 == 32'd0);

    // prepare unsigned division for p
    c8     = s7_q;
    b7     = ({13'd0, s7_q.up} - s7_q.b3) * (32'd50000 >> oss_q);
    c8.dbl = b7[31];
    c8.a   = b7[31] ? b7 : (b7 << 1);
    c8.d   = s7_q.b4;
    c8.r   = '0;

    c9   = dv2_q[bpc_pkg::DivSteps-1];
    c9.p = c9.dbl ? (c9.a << 1) : c9.a;

    c10     = s9_q;
    pp      = 32'($signed(s9_q.p) >>> 8);
    pm1     = -32'd7357 * s9_q.p;
    c10.px1 = pp * pp;
    c10.px2 = 32'($signed(pm1) >>> 16);

    c11      = s10_q;
    pm2      = s10_q.px1 * 32'd3038;
    c11.px1b = 32'($signed(pm2) >>> 16);

    c12 = s11_q;
    pf  = s11_q.p + 32'($signed(s11_q.px1b + s11_q.px2 + 32'd3791) >>> 4);
    if (s11_q.dz || s11_q.bz || pf[31]) begin
      c12.pa = '0;
    end else if (pf[30:18] != 13'd0) begin
      c12.pa = 18'h3ffff;
    end else begin
      c12.pa = pf[17:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q     <= c0;
      s1_q     <= c1;
      s2_q     <= c2;
      dv1_q[0] <= bpc_pkg::div_step(s2_q);
      for (int i = 1; i < bpc_pkg::DivSteps; i++) begin
        dv1_q[i] <= bpc_pkg::div_step(dv1_q[i-1]);
      end
      s3_q     <= c3;
      s4_q     <= c4;
      s5_q     <= c5;
      s6_q     <= c6;
      s7_q     <= c7;
      s8_q     <= c8;
      dv2_q[0] <= bpc_pkg::div_step(s8_q);
      for (int i = 1; i < bpc_pkg::DivSteps; i++) begin
        dv2_q[i] <= bpc_pkg::div_step(dv2_q[i-1]);
      end
      s9_q     <= c9;
      s10_q    <= c10;
      s11_q    <= c11;
      s12_q    <= c12;
    end
  end

  assign temperature_tenths_o = s12_q.temp;
  assign pressure_pa_o        = s12_q.pa;
  assign math_error_o         = s12_q.dz | s12_q.bz;

`ifndef NO_ASSERTIONS
  a_err_clears_pressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && math_error_o |-> pressure_pa_o == 18'd0)
    else $error("pressure not cleared on math error");
  a_tdiv_clears_temp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && s12_q.dz |-> temperature_tenths_o == 16'd0)
    else $error("temperature not cleared on zero divisor");
  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vld_q))
    else $error("pipeline moved while stalled");
`endif

endmodule
